/* rtl/core/vec3_fixed_alu_top_defines.svh */
// Assertion macros for the vector ALU RTL.
// Expect clk and rst_n in scope at each use.
`ifndef VEC3_FIXED_ALU_TOP_DEFINES_SVH
`define VEC3_FIXED_ALU_TOP_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define VFA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/vfa_pkg.sv */
// Package for the vector ALU: widths, opcode type, queue and pipeline records,
// saturation and rounding helpers. No dependencies.
`timescale 1ns / 1ps

package vfa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SAT_W     = PROD_W + 4;
    localparam int SQ_W      = PROD_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 4;
    localparam int LEN_W     = ROOT_W + 1;
    localparam int DVS_W     = LEN_W;
    localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
    localparam int ROUND_W   = DATA_W + 2;
    localparam int IN_W      = 7 * DATA_W;
    localparam int OUT_W     = 4 * DATA_W;
    localparam int OP_W      = 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = QPTR_W + 1;

    localparam logic [DATA_W-1:0] WMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] WMIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SAT_W-1:0] HALF_S = SAT_W'(1) <<< (FRAC_BITS - 1);
    localparam logic [ROUND_W-1:0] HALF_R = ROUND_W'(1) << (FRAC_BITS - 1);
    localparam logic [ROUND_W-1:0] MASK_R = (ROUND_W'(1) << FRAC_BITS) - 1'b1;
    localparam logic [DATA_W-1:0] RXY_MAX = WMAX & ~MASK_R[DATA_W-1:0];

    typedef enum logic [OP_W-1:0] {
        OP_ADD, OP_SUB, OP_SCALE, OP_DIV, OP_DOT, OP_LEN, OP_NORM, OP_RXY
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [2:0][DATA_W-1:0]  a;
        logic [2:0][DATA_W-1:0]  b;
        logic [DATA_W-1:0]       s;
        logic [2:0][PROD_W-1:0]  p;
    } q_entry_t;

    typedef struct packed {
        op_t                     op;
        logic [2:0][DATA_W-1:0]  r;
        logic [DATA_W-1:0]       sc;
        logic                    flag;
        logic [2:0]              a_neg;
        logic [2:0][DATA_W-1:0]  a_mag;
        logic                    s_neg;
        logic [DATA_W-1:0]       s_mag;
        logic                    s_zero;
        logic                    sq_zero;
    } meta_t;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } sat_t;

    function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
        sat_t res;
        res.ovf = !((&v[SAT_W-1:DATA_W-1]) || !(|v[SAT_W-1:DATA_W-1]));
        res.val = res.ovf ? (v[SAT_W-1] ? WMIN : WMAX) : v[DATA_W-1:0];
        return res;
    endfunction

    // Round to nearest integer, ties away from zero; clamp positive overflow.
    function automatic sat_t round_xy(input logic [DATA_W-1:0] v);
        logic [DATA_W:0]    m;
        logic [ROUND_W-1:0] t;
        logic [ROUND_W-1:0] r;
        logic [ROUND_W-1:0] rn;
        sat_t               res;
        m  = v[DATA_W-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        t  = {1'b0, m} + HALF_R;
        r  = t & ~MASK_R;
        rn = ROUND_W'(0) - r;
        res.ovf = 1'b0;
        if (v[DATA_W-1]) begin
            res.val = rn[DATA_W-1:0];
        end else if (r > ROUND_W'(WMAX)) begin
            res.ovf = 1'b1;
            res.val = RXY_MAX;
        end else begin
            res.val = r[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

/* rtl/core/vec3_fixed_alu_top.sv */
// Three-component Q16.16 vector ALU: add, sub, scale, divide, dot, length,
// normalize and round-xy on a stream, one transfer accepted per cycle while the queue has room.
// Back end: the 32-step root pipeline and the 49-step divider pipeline.
// Throughput: one result per cycle while the output side keeps up.
// Reset: rst_n clears all valid flags and queue pointers; data holds no state.
`timescale 1ns / 1ps

module vec3_fixed_alu_top (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input transfer.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // s_tdata from bit 0 up: ax, ay, az, bx, by_comp, bz, scalar_in (32 each)
    input  logic [vfa_pkg::IN_W-1:0]   s_tdata,
    // s_tuser: opcode (3 bits)
    input  logic [vfa_pkg::OP_W-1:0]   s_tuser,
    // Result transfer.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata from bit 0 up: rx, ry, rz, scalar_out (32 each)
    output logic [vfa_pkg::OUT_W-1:0]  m_tdata,
    // m_tuser: flag (divide by zero, zero-length normalize or saturation)
    output logic [0:0]                 m_tuser
);
    import vfa_pkg::*;

    // Front end to queue.
    logic      q_push;
    q_entry_t  q_wr_entry;
    logic      q_full;

    // Queue to back end.
    q_entry_t  q_head;
    logic      q_empty;
    logic      q_pop;

    // Decode the opcode and form the products; stall only when the queue fills.
    vfa_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (q_push),
        .entry    (q_wr_entry)
    );

    // Decouple the front end from back-pressure in the execute pipeline.
    vfa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    // Execute: simple ops, square root, division and the output register.
    vfa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/vfa_front.sv */
// Front end: accepts input transfers, decodes the opcode and forms the
// per-lane products. Depends on vfa_pkg.
`timescale 1ns / 1ps

module vfa_front (
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [vfa_pkg::IN_W-1:0]  s_tdata,
    input  logic [vfa_pkg::OP_W-1:0]  s_tuser,
    input  logic                      q_full,
    output logic                      push,
    output vfa_pkg::q_entry_t         entry
);
    import vfa_pkg::*;

    typedef enum logic [1:0] { MSEL_A, MSEL_B, MSEL_S } msel_t;

    msel_t msel;
    op_t   op;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;
    assign op       = op_t'(s_tuser);

    always_comb
    begin
        unique case (op)
            OP_SCALE:         msel = MSEL_S;
            OP_DOT:           msel = MSEL_B;
            default:          msel = MSEL_A;
        endcase
    end

    always_comb
    begin
        logic signed [DATA_W-1:0] mb;
        logic signed [DATA_W-1:0] av;
        entry    = '0;
        entry.op = op;
        entry.s  = s_tdata[6*DATA_W +: DATA_W];
        for (int i = 0; i < 3; i++)
        begin
            entry.a[i] = s_tdata[i*DATA_W +: DATA_W];
            entry.b[i] = s_tdata[(i+3)*DATA_W +: DATA_W];
            av = $signed(entry.a[i]);
            unique case (msel)
                MSEL_S:  mb = $signed(entry.s);
                MSEL_B:  mb = $signed(entry.b[i]);
                default: mb = av;
            endcase
            entry.p[i] = PROD_W'(av * mb);
        end
    end

endmodule

/* rtl/core/vfa_queue.sv */
// Short queue between the front end and the execute pipeline.
// Depends on vfa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "vec3_fixed_alu_top_defines.svh"

module vfa_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vfa_pkg::q_entry_t wr_entry,
    input  logic              pop,
    output vfa_pkg::q_entry_t head,
    output logic              full,
    output logic              empty
);
    import vfa_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    `VFA_ASSERT_ALWAYS(a_count_bound, count_reg <= QCNT_W'(QDEPTH), "queue count over depth")
    `VFA_ASSERT_ALWAYS(a_ptr_gap, QPTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QPTR_W-1:0], "queue pointers disagree with count")
    `VFA_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a push")
    `VFA_ASSERT_NEXT(a_pop_drains, pop && !push, count_reg == QCNT_W'($past(count_reg) - 1'b1), "queue count wrong after a pop")

endmodule

/* rtl/core/vfa_sqrt.sv */
// Pipelined integer square root, one result bit per stage, with round to
// nearest in a final stage. Depends on vfa_pkg.
`timescale 1ns / 1ps

module vfa_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [vfa_pkg::SQ_W-1:0]   in_sq,
    input  vfa_pkg::meta_t             in_meta,
    output logic                       out_valid,
    output logic [vfa_pkg::LEN_W-1:0]  out_len,
    output vfa_pkg::meta_t             out_meta
);
    import vfa_pkg::*;

    logic              valid_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [SQ_W-1:0]   rad_reg   [ROOT_W];
    meta_t             meta_reg  [ROOT_W];

    logic              out_valid_reg;
    logic [LEN_W-1:0]  len_reg, len_next;
    meta_t             out_meta_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in, cur, trial, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        logic [SQ_W-1:0]   rad_in;
        meta_t             m_in;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_sq;
            assign m_in    = in_meta;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign m_in    = meta_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in[REM_W-3:0], rad_in[SQ_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W-2){1'b0}}, root_in, 2'b01};
            if (cur >= trial)
            begin
                rem_next  = cur - trial;
                root_next = {root_in[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = cur;
                root_next = {root_in[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= {rad_in[SQ_W-3:0], 2'b00};
                meta_reg[k] <= m_in;
            end
        end
    end

    // Round up when the remainder exceeds the floor root.
    assign len_next = {1'b0, root_reg[ROOT_W-1]}
                    + LEN_W'(rem_reg[ROOT_W-1] > REM_W'(root_reg[ROOT_W-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= valid_reg[ROOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg      <= len_next;
            out_meta_reg <= meta_reg[ROOT_W-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_len   = len_reg;
    assign out_meta  = out_meta_reg;

endmodule

/* rtl/core/vfa_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Depends on vfa_pkg.
`timescale 1ns / 1ps

module vfa_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][vfa_pkg::NUM_W-1:0]      in_num,
    input  logic [vfa_pkg::DVS_W-1:0]           in_dvs,
    input  vfa_pkg::meta_t                      in_meta,
    output logic                                out_valid,
    output logic [2:0][vfa_pkg::NUM_W-1:0]      out_quo,
    output vfa_pkg::meta_t                      out_meta
);
    import vfa_pkg::*;

    logic             valid_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg    [NUM_W][3];
    logic [DVS_W-1:0] rem_reg   [NUM_W][3];
    logic [DVS_W-1:0] dvs_reg   [NUM_W];
    meta_t            meta_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             v_in;
        logic [DVS_W-1:0] dvs_in;
        meta_t            m_in;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign dvs_in = in_dvs;
            assign m_in   = in_meta;
        end
        else
        begin : g_rest
            assign v_in   = valid_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign m_in   = meta_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dvs_reg[k]  <= dvs_in;
                meta_reg[k] <= m_in;
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_lane
            logic [NUM_W-1:0] nq_in;
            logic [DVS_W-1:0] rem_in, rem_next;
            logic [DVS_W:0]   cur, diff;
            logic             qbit;

            if (k == 0)
            begin : g_first
                assign nq_in  = in_num[j];
                assign rem_in = '0;
            end
            else
            begin : g_rest
                assign nq_in  = nq_reg[k-1][j];
                assign rem_in = rem_reg[k-1][j];
            end

            always_comb
            begin
                cur      = {rem_in, nq_in[NUM_W-1]};
                diff     = cur - {1'b0, dvs_in};
                qbit     = (cur >= {1'b0, dvs_in});
                rem_next = qbit ? diff[DVS_W-1:0] : cur[DVS_W-1:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k][j] <= rem_next;
                    nq_reg[k][j]  <= {nq_in[NUM_W-2:0], qbit};
                end
            end
        end
    end

    assign out_valid  = valid_reg[NUM_W-1];
    assign out_meta   = meta_reg[NUM_W-1];
    assign out_quo[0] = nq_reg[NUM_W-1][0];
    assign out_quo[1] = nq_reg[NUM_W-1][1];
    assign out_quo[2] = nq_reg[NUM_W-1][2];

endmodule

/* rtl/core/vfa_back.sv */
// Execute pipeline: simple ops, square root, divide and the output register.
// Depends on vfa_pkg, vfa_sqrt and vfa_div.
`timescale 1ns / 1ps

module vfa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  vfa_pkg::q_entry_t          head,
    input  logic                       q_empty,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [vfa_pkg::OUT_W-1:0]  m_tdata,
    output logic [0:0]                 m_tuser
);
    import vfa_pkg::*;

    logic                    en;
    logic                    e0_valid_reg;
    meta_t                   e0_meta_reg, e0_meta_next;
    logic [SQ_W-1:0]         e0_sq_reg, e0_sq_next;

    logic                    sq_valid;
    logic [LEN_W-1:0]        sq_len;
    meta_t                   sq_meta;

    logic                    p_valid_reg;
    logic [2:0][NUM_W-1:0]   p_num_reg, p_num_next;
    logic [DVS_W-1:0]        p_dvs_reg, p_dvs_next;
    meta_t                   p_meta_reg, p_meta_next;

    logic                    d_valid;
    logic [2:0][NUM_W-1:0]   d_quo;
    meta_t                   d_meta;

    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg, m_data_next;
    logic                    m_flag_reg, m_flag_next;

    // Whole pipeline advances together unless the output holds a result that is not taken.
    assign en  = !m_valid_reg || m_tready;
    assign pop = en && !q_empty;

    always_comb
    begin
        logic signed [DATA_W-1:0] a_v, b_v;
        logic signed [PROD_W-1:0] p_v;
        logic signed [SAT_W-1:0]  dot_sum;
        sat_t                     add_s [3];
        sat_t                     sub_s [3];
        sat_t                     scl_s [3];
        sat_t                     dot_s;
        sat_t                     rx_s, ry_s;
        e0_meta_next    = '0;
        e0_meta_next.op = head.op;
        e0_sq_next      = '0;
        dot_sum         = HALF_S;
        for (int i = 0; i < 3; i++)
        begin
            a_v      = $signed(head.a[i]);
            b_v      = $signed(head.b[i]);
            p_v      = $signed(head.p[i]);
            add_s[i] = sat_word(SAT_W'(a_v) + SAT_W'(b_v));
            sub_s[i] = sat_word(SAT_W'(a_v) - SAT_W'(b_v));
            scl_s[i] = sat_word((SAT_W'(p_v) + HALF_S) >>> FRAC_BITS);
            dot_sum  = dot_sum + SAT_W'(p_v);
            e0_sq_next = e0_sq_next + head.p[i];
            e0_meta_next.a_neg[i] = head.a[i][DATA_W-1];
            e0_meta_next.a_mag[i] = head.a[i][DATA_W-1] ? (~head.a[i] + 1'b1) : head.a[i];
        end
        dot_s = sat_word(dot_sum >>> FRAC_BITS);
        rx_s  = round_xy(head.a[0]);
        ry_s  = round_xy(head.a[1]);
        e0_meta_next.s_neg   = head.s[DATA_W-1];
        e0_meta_next.s_mag   = head.s[DATA_W-1] ? (~head.s + 1'b1) : head.s;
        e0_meta_next.s_zero  = (head.s == '0);
        e0_meta_next.sq_zero = (e0_sq_next == '0);

        unique case (head.op)
            OP_ADD:
            begin
                for (int i = 0; i < 3; i++)
                    e0_meta_next.r[i] = add_s[i].val;
                e0_meta_next.flag = add_s[0].ovf | add_s[1].ovf | add_s[2].ovf;
            end
            OP_SUB:
            begin
                for (int i = 0; i < 3; i++)
                    e0_meta_next.r[i] = sub_s[i].val;
                e0_meta_next.flag = sub_s[0].ovf | sub_s[1].ovf | sub_s[2].ovf;
            end
            OP_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                    e0_meta_next.r[i] = scl_s[i].val;
                e0_meta_next.flag = scl_s[0].ovf | scl_s[1].ovf | scl_s[2].ovf;
            end
            OP_DOT:
            begin
                e0_meta_next.sc   = dot_s.val;
                e0_meta_next.flag = dot_s.ovf;
            end
            OP_RXY:
            begin
                e0_meta_next.r[0] = rx_s.val;
                e0_meta_next.r[1] = ry_s.val;
                e0_meta_next.r[2] = head.a[2];
                e0_meta_next.flag = rx_s.ovf | ry_s.ovf;
            end
            default:
            begin
                // Divide, length and normalize finish further down the pipe.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e0_valid_reg <= 1'b0;
        else if (en)
            e0_valid_reg <= !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_meta_reg <= e0_meta_next;
            e0_sq_reg   <= e0_sq_next;
        end
    end

    vfa_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e0_valid_reg),
        .in_sq     (e0_sq_reg),
        .in_meta   (e0_meta_reg),
        .out_valid (sq_valid),
        .out_len   (sq_len),
        .out_meta  (sq_meta)
    );

    // Pick the divisor and pre-add half of it for round to nearest.
    always_comb
    begin
        sat_t len_s;
        p_meta_next = sq_meta;
        p_dvs_next  = (sq_meta.op == OP_DIV) ? {1'b0, sq_meta.s_mag} : sq_len;
        for (int i = 0; i < 3; i++)
            p_num_next[i] = NUM_W'({sq_meta.a_mag[i], {FRAC_BITS{1'b0}}})
                          + NUM_W'(p_dvs_next >> 1);
        len_s = sat_word(SAT_W'({1'b0, sq_len}));
        if (sq_meta.op == OP_LEN)
        begin
            p_meta_next.sc   = len_s.val;
            p_meta_next.flag = len_s.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_num_reg  <= p_num_next;
            p_dvs_reg  <= p_dvs_next;
            p_meta_reg <= p_meta_next;
        end
    end

    vfa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .in_num    (p_num_reg),
        .in_dvs    (p_dvs_reg),
        .in_meta   (p_meta_reg),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_meta  (d_meta)
    );

    // Apply quotient sign, saturate, and override the zero-divisor cases.
    always_comb
    begin
        logic                     neg;
        logic signed [SAT_W-1:0]  qs;
        sat_t                     q_s;
        logic [2:0][DATA_W-1:0]   r;
        logic                     flag;
        r    = d_meta.r;
        flag = d_meta.flag;
        unique case (d_meta.op)
            OP_DIV, OP_NORM:
            begin
                if ((d_meta.op == OP_DIV) ? d_meta.s_zero : d_meta.sq_zero)
                begin
                    r    = '0;
                    flag = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        neg  = d_meta.a_neg[i] ^ ((d_meta.op == OP_DIV) && d_meta.s_neg);
                        qs   = SAT_W'({1'b0, d_quo[i]});
                        q_s  = sat_word(neg ? -qs : qs);
                        r[i] = q_s.val;
                        flag = flag | q_s.ovf;
                    end
                end
            end
            default:
            begin
                // Result already settled earlier in the pipe.
            end
        endcase
        m_data_next = {d_meta.sc, r[2], r[1], r[0]};
        m_flag_next = flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= d_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= m_data_next;
            m_flag_reg <= m_flag_next;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_flag_reg;

endmodule

/* test/tb_vec3_fixed_alu_top.sv */
// Self-checking testbench for vec3_fixed_alu_top: directed and random vector
// operations with bursty input and a stalling result side. Depends on vfa_pkg.
`timescale 1ns / 1ps

module tb_vec3_fixed_alu_top;
    import vfa_pkg::*;

    localparam int N_RANDOM   = 1300;
    localparam int PAUSE_AT   = 650;   // random item that waits for a drained pipe
    localparam int TAIL_WAIT  = 200;   // well past the pipeline latency

    typedef struct {
        op_t               op;
        logic [31:0]       a [3];
        logic [31:0]       b [3];
        logic [31:0]       s;
        bit                drain_first;
    } vec_op_t;

    typedef struct {
        logic [31:0] r [3];
        logic [31:0] sc;
        logic        flag;
    } vec_res_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic [0:0]          m_tuser;

    vec_op_t  op_queue [$];
    vec_res_t result_queue [$];
    vec_op_t  in_flight;
    int       mismatches;
    int       results_seen;
    int       flagged_seen;
    int       burst_left;
    int       gap_left;
    int       cycle_cnt;

    vec3_fixed_alu_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Clamp an exact value to a 32-bit word; raise the flag when it does not fit.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic f);
        if (v > 128'sh7FFF_FFFF)
        begin
            f = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -128'sh8000_0000)
        begin
            f = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Quotient rounded to nearest, ties away from zero; den is never zero.
    function automatic logic signed [127:0] quot_round(input longint num, input longint den);
        logic [63:0] un;
        logic [63:0] ud;
        logic [63:0] q;
        un = (num < 0) ? 64'(-num) : 64'(num);
        ud = (den < 0) ? 64'(-den) : 64'(den);
        q  = (un + ud / 2) / ud;
        if ((num < 0) != (den < 0))
            return -$signed({64'd0, q});
        return $signed({64'd0, q});
    endfunction

    // Square root of a 64-bit sum of squares, rounded to nearest.
    function automatic logic [63:0] root_round(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = n;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= root + probe)
            begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        if (rem > root)
            root = root + 1;
        return root;
    endfunction

    // Nearest integer, ties away from zero; positive overflow clamps to 0x7FFF0000.
    function automatic logic [31:0] round_to_int(input logic [31:0] w, inout logic f);
        longint v;
        longint m;
        longint t;
        v = longint'($signed(w));
        m = (v < 0) ? -v : v;
        t = m + 64'sd32768;
        t = t - (t & 64'sd65535);
        if (v < 0)
            return 32'(-t);
        if (t > 64'sh7FFF_FFFF)
        begin
            f = 1'b1;
            return 32'h7FFF_0000;
        end
        return t[31:0];
    endfunction

    function automatic vec_res_t vector_result(input vec_op_t it);
        vec_res_t             res;
        longint               av [3];
        longint               bv [3];
        longint               sv;
        logic signed [127:0]  acc;
        logic [63:0]          sq;
        logic [63:0]          len;
        logic                 f;
        f = 1'b0;
        res.r[0] = 0;
        res.r[1] = 0;
        res.r[2] = 0;
        res.sc = 0;
        sv = longint'($signed(it.s));
        for (int i = 0; i < 3; i++)
        begin
            av[i] = longint'($signed(it.a[i]));
            bv[i] = longint'($signed(it.b[i]));
        end
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq = sq + 64'(av[i] * av[i]);
        case (it.op)
            OP_ADD:
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp32(128'(av[i] + bv[i]), f);
            OP_SUB:
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp32(128'(av[i] - bv[i]), f);
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                    res.r[i] = clamp32((128'(av[i] * sv) + 128'sd32768) >>> 16, f);
            OP_DIV:
                if (sv == 0)
                    f = 1'b1;
                else
                    for (int i = 0; i < 3; i++)
                        res.r[i] = clamp32(quot_round(av[i] * 65536, sv), f);
            OP_DOT:
            begin
                acc = 128'sd32768;
                for (int i = 0; i < 3; i++)
                    acc = acc + 128'(av[i] * bv[i]);
                res.sc = clamp32(acc >>> 16, f);
            end
            OP_LEN:
            begin
                len = root_round(sq);
                res.sc = clamp32($signed({64'd0, len}), f);
            end
            OP_NORM:
            begin
                len = root_round(sq);
                if (sq == 0)
                    f = 1'b1;
                else
                    for (int i = 0; i < 3; i++)
                        res.r[i] = clamp32(quot_round(av[i] * 65536, longint'(len)), f);
            end
            default:
            begin
                res.r[0] = round_to_int(it.a[0], f);
                res.r[1] = round_to_int(it.a[1], f);
                res.r[2] = it.a[2];
            end
        endcase
        res.flag = f;
        return res;
    endfunction

    // Mix of full-range words, small magnitudes and the extremes.
    function automatic logic [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom;
        if (sel < 7)
            return 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
        if (sel == 7)
            return 32'h7FFF_FFFF;
        if (sel == 8)
            return 32'h8000_0000;
        return ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(0, 5)) << 15;
    endfunction

    function automatic vec_op_t make_op(input op_t op, input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z, input logic [31:0] s);
        vec_op_t it;
        it.op = op;
        it.a[0] = x;
        it.a[1] = y;
        it.a[2] = z;
        it.b[0] = ~y;
        it.b[1] = z;
        it.b[2] = x;
        it.s = s;
        it.drain_first = 1'b0;
        return it;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch #%0d at result %0d: %s got %h want %h",
                 mismatches, results_seen, what, got, want);
        mismatches++;
    endtask

    // Driver: hold the current transfer until accepted, then advance in bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                result_queue.push_back(vector_result(in_flight));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (op_queue.size() != 0 &&
                         !(op_queue[0].drain_first &&
                           (result_queue.size() != 0 || s_tvalid)))
                begin
                    in_flight = op_queue.pop_front();
                    s_tdata  <= {in_flight.s, in_flight.b[2], in_flight.b[1], in_flight.b[0],
                                 in_flight.a[2], in_flight.a[1], in_flight.a[0]};
                    s_tuser  <= in_flight.op;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: steps through its stall modes in turn, from always ready to mostly stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            cycle_cnt <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            case ((cycle_cnt / 300) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                2: m_tready <= ((cycle_cnt % 7) < 4);
                default: m_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // Monitor: compare each result transfer against the oldest prediction.
    always @(posedge clk)
    begin
        vec_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (result_queue.size() == 0)
            begin
                report("unexpected rx", m_tdata[31:0], 32'h0);
            end
            else
            begin
                want = result_queue.pop_front();
                if (m_tdata[31:0] !== want.r[0])
                    report("rx", m_tdata[31:0], want.r[0]);
                if (m_tdata[63:32] !== want.r[1])
                    report("ry", m_tdata[63:32], want.r[1]);
                if (m_tdata[95:64] !== want.r[2])
                    report("rz", m_tdata[95:64], want.r[2]);
                if (m_tdata[127:96] !== want.sc)
                    report("scalar_out", m_tdata[127:96], want.sc);
                if (m_tuser[0] !== want.flag)
                    report("flag", 32'(m_tuser[0]), 32'(want.flag));
                flagged_seen += want.flag;
            end
            results_seen++;
        end
    end

    initial
    begin
        vec_op_t it;
        mismatches   = 0;
        results_seen = 0;
        flagged_seen = 0;
        rst_n = 1'b0;

        // Directed: extremes, every opcode, the zero and rounding corner cases.
        op_queue.push_back(make_op(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0));
        op_queue.push_back(make_op(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
                                   32'h8000_0000));
        op_queue.push_back(make_op(OP_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000,
                                   32'h0000_8000));
        op_queue.push_back(make_op(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h3, 32'h0));
        op_queue.push_back(make_op(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_0000,
                                   32'h0000_0001));
        op_queue.push_back(make_op(OP_DIV, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0005_0000,
                                   32'h0002_0000));
        op_queue.push_back(make_op(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
        op_queue.push_back(make_op(OP_DOT, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'h0));
        op_queue.push_back(make_op(OP_LEN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
        op_queue.push_back(make_op(OP_LEN, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_LEN, 32'h0, 32'h0, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_NORM, 32'h0, 32'h0, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_NORM, 32'h0000_0001, 32'h0, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_NORM, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_NORM, 32'h0003_0000, 32'hFFFC_0000, 32'h0, 32'h0));
        op_queue.push_back(make_op(OP_RXY, 32'h7FFF_8000, 32'h8000_0000, 32'h1234_5678, 32'h0));
        op_queue.push_back(make_op(OP_RXY, 32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_FFFF, 32'h0));
        op_queue.push_back(make_op(OP_RXY, 32'h7FFF_FFFF, 32'h0001_7FFF, 32'h8000_0000, 32'h0));
        op_queue.push_back(make_op(OP_RXY, 32'h7FFF_7FFF, 32'hFFFE_8001, 32'h0, 32'h0));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            it.op = op_t'($urandom_range(0, 7));
            for (int i = 0; i < 3; i++)
            begin
                it.a[i] = pick_word();
                it.b[i] = pick_word();
            end
            it.s = pick_word();
            it.drain_first = (n == PAUSE_AT);
            op_queue.push_back(it);
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Advance until every item is sent and every prediction is matched.
        wait (op_queue.size() == 0 && !s_tvalid);
        wait (result_queue.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);

        $display("covered %0d result transfers over all eight opcodes, %0d with flag set,",
                 results_seen, flagged_seen);
        $display("under bursty input and four result-side stall modes");
        if (mismatches == 0 && result_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d predictions still waiting", result_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
